// ===== design/brbf_pkg.sv =====
// Shared types and constants for the byte ring buffer FIFO.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package brbf_pkg;

    localparam int DATA_W  = 8;
    localparam int LEN_W   = 7;
    localparam int SIZE_W  = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 3'd6;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_PEEK  = 2'd2,
        ACT_CLEAR = 2'd3
    } action_t;

    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE   = 2'd1;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // request transfer in this cycle
        logic load;     // capture one read/peek byte into the response
        logic done;     // response transfer that ends the operation
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic start_read;   // accepted request is a non-empty read or peek
        logic more;         // read/peek bytes remain after the current one
    } status_t;

endpackage

`default_nettype wire

// ===== design/brbf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module brbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== design/brbf_ctrl.sv =====
// Operation sequencer for the byte ring buffer FIFO.
// Depends on brbf_pkg; drives the request stall and response valid.
`default_nettype none

module brbf_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    input  wire brbf_pkg::status_t status,
    output brbf_pkg::cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_LOAD  = 4'b0100,
        S_RESP  = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        rsp_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                req_stall  = 1'b0;
                cmd.accept = req_valid;
                if (req_valid)
                begin
                    state_next = status.start_read ? S_FETCH : S_RESP;
                end
            end
            S_FETCH:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_RESP;
            end
            S_RESP:
            begin
                rsp_valid = 1'b1;
                if (!rsp_stall)
                begin
                    if (status.more)
                    begin
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        cmd.done   = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

// ===== design/brbf_dpath.sv =====
// Pointers, run state, configuration and response registers of the FIFO.
// Depends on brbf_pkg; drives the storage RAM ports.
`default_nettype none

module brbf_dpath #(
    parameter int DEPTH = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire brbf_pkg::cmd_t                   cmd,
    output brbf_pkg::status_t                     status,
    input  wire logic                             cfg_we,
    input  wire logic [brbf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [brbf_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  wire logic [1:0]                       action,
    input  wire logic [brbf_pkg::DATA_W-1:0]      data_byte,
    input  wire logic [brbf_pkg::LEN_W-1:0]       length,
    input  wire logic                             first_of_run,
    output logic                                  ram_we,
    output logic [$clog2(DEPTH)-1:0]              ram_waddr,
    output logic [brbf_pkg::DATA_W-1:0]           ram_wdata,
    output logic [$clog2(DEPTH)-1:0]              ram_raddr,
    input  wire logic [brbf_pkg::DATA_W-1:0]      ram_rdata,
    output logic [brbf_pkg::DATA_W-1:0]           out_byte,
    output logic [brbf_pkg::LEN_W-1:0]            count,
    output logic                                  accepted,
    output logic                                  last
);

    localparam int AW   = $clog2(DEPTH);
    localparam int MAXL = $clog2(DEPTH + 1) - 1;
    localparam int LW   = brbf_pkg::LEN_W;
    localparam int SW   = brbf_pkg::SIZE_W;

    logic [AW-1:0]  head_reg, head_next;
    logic [AW-1:0]  tail_reg, tail_next;
    logic           refused_reg, refused_next;
    logic [LW-1:0]  written_reg, written_next;
    logic           enable_reg, enable_next;
    logic [SW-1:0]  size_reg, size_next;
    logic           multi_reg, multi_next;
    logic           pop_reg, pop_next;

    logic [AW-1:0]  rd_ptr_reg;
    logic [LW-1:0]  n_reg;
    logic [LW-1:0]  k_reg;
    logic [brbf_pkg::DATA_W-1:0] byte_reg;
    logic [LW-1:0]  count_reg;
    logic           accepted_reg;
    logic           last_reg;

    brbf_pkg::action_t act;
    logic [SW-1:0]  lvl;
    logic [AW:0]    one_sh;
    logic [AW-1:0]  mask;
    logic [AW-1:0]  free_sp;
    logic [AW-1:0]  used_sp;
    logic [LW-1:0]  n_calc;
    logic           rd_empty;
    logic           run_refused;
    logic [LW-1:0]  run_base;
    logic           store;
    logic [LW-1:0]  run_count;
    logic [LW-1:0]  k_inc;

    assign act = brbf_pkg::action_t'(action);

    always_comb
    begin
        lvl = (size_reg == '0) ? SW'(1) : size_reg;
        if (lvl > SW'(MAXL))
        begin
            lvl = SW'(MAXL);
        end
        one_sh = ({{AW{1'b0}}, 1'b1} << lvl) - {{AW{1'b0}}, 1'b1};
        mask   = one_sh[AW-1:0];
    end

    assign free_sp = (tail_reg - head_reg - AW'(1)) & mask;
    assign used_sp = mask - free_sp;
    assign n_calc  = (LW'(used_sp) < length) ? LW'(used_sp) : length;
    assign rd_empty = !enable_reg || (n_calc == '0);

    assign run_refused = first_of_run ? (!enable_reg || (LW'(free_sp) < length)) : refused_reg;
    assign run_base    = first_of_run ? '0 : written_reg;
    assign store       = enable_reg && !run_refused && (run_base < length) && (free_sp != '0);
    assign run_count   = run_base + LW'(store);

    assign k_inc = k_reg + LW'(1);

    assign status.start_read = ((act == brbf_pkg::ACT_READ) || (act == brbf_pkg::ACT_PEEK))
                               && !rd_empty;
    assign status.more       = multi_reg && (k_reg != n_reg);

    assign ram_we    = cmd.accept && (act == brbf_pkg::ACT_WRITE) && store;
    assign ram_waddr = head_reg;
    assign ram_wdata = data_byte;
    assign ram_raddr = rd_ptr_reg;

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        refused_next = refused_reg;
        written_next = written_reg;
        enable_next  = enable_reg;
        size_next    = size_reg;
        multi_next   = multi_reg;
        pop_next     = pop_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                brbf_pkg::CFG_ENABLE:
                begin
                    enable_next  = cfg_data[0];
                    head_next    = '0;
                    tail_next    = '0;
                    refused_next = 1'b0;
                    written_next = '0;
                end
                brbf_pkg::CFG_SIZE:
                begin
                    size_next    = cfg_data;
                    head_next    = '0;
                    tail_next    = '0;
                    refused_next = 1'b0;
                    written_next = '0;
                end
                default:
                begin
                end
            endcase
        end
        else if (cmd.accept)
        begin
            multi_next = 1'b0;
            case (act)
                brbf_pkg::ACT_WRITE:
                begin
                    refused_next = run_refused;
                    written_next = run_count;
                    if (store)
                    begin
                        head_next = (head_reg + AW'(1)) & mask;
                    end
                end
                brbf_pkg::ACT_CLEAR:
                begin
                    head_next = '0;
                    tail_next = '0;
                end
                default:
                begin
                    multi_next = !rd_empty;
                    pop_next   = (act == brbf_pkg::ACT_READ);
                end
            endcase
        end
        else if (cmd.done)
        begin
            if (multi_reg && pop_reg)
            begin
                tail_next = rd_ptr_reg;
            end
            multi_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            refused_reg <= 1'b0;
            written_reg <= '0;
            enable_reg  <= 1'b0;
            size_reg    <= brbf_pkg::SIZE_RESET;
            multi_reg   <= 1'b0;
            pop_reg     <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            refused_reg <= refused_next;
            written_reg <= written_next;
            enable_reg  <= enable_next;
            size_reg    <= size_next;
            multi_reg   <= multi_next;
            pop_reg     <= pop_next;
        end
    end

    // response payload and read walk
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            byte_reg     <= '0;
            count_reg    <= '0;
            accepted_reg <= 1'b0;
            last_reg     <= 1'b1;
            rd_ptr_reg   <= tail_reg;
            n_reg        <= n_calc;
            k_reg        <= '0;
            if (act == brbf_pkg::ACT_WRITE)
            begin
                count_reg    <= run_count;
                accepted_reg <= store;
            end
        end
        else if (cmd.load)
        begin
            byte_reg     <= ram_rdata;
            count_reg    <= k_inc;
            accepted_reg <= 1'b1;
            last_reg     <= (k_inc == n_reg);
            k_reg        <= k_inc;
            rd_ptr_reg   <= (rd_ptr_reg + AW'(1)) & mask;
        end
    end

    assign out_byte = byte_reg;
    assign count    = count_reg;
    assign accepted = accepted_reg;
    assign last     = last_reg;

endmodule

`default_nettype wire

// ===== design/byte_ring_buffer_fifo_top.sv =====
// Top level of the byte ring buffer FIFO.
// Depends on brbf_pkg, brbf_ram, brbf_ctrl and brbf_dpath.
//
// Request channel (req_valid/req_stall): action, data_byte, length,
// first_of_run. Response channel (rsp_valid/rsp_stall): out_byte, count,
// accepted, last. A transfer happens when valid is high and stall is low.
// Configuration channel (cfg_valid/cfg_ready): cfg_index 0 enable,
// 1 size_log2; a write to either clears the pointers and run state.
// cfg_ready is always high; write it only while no operation is in flight.
//
// Write, clear and empty read/peek: one response, valid the cycle after
// the request transfer. Non-empty read/peek of n bytes: the first byte is
// valid after the controller passes through its fetch and load states,
// then each further byte after another load state while the receiver
// keeps up; the registered read port of the storage RAM sets this pace.
// A new request is taken in the cycle after the last response transfers.
// While rsp_stall is high the response holds and req_stall stays high.
// Reset: pointers and run state zero, disabled, size_log2 6, no response
// pending. Storage is not cleared; nothing unwritten is ever read.
`default_nettype none

module byte_ring_buffer_fifo_top #(
    parameter int DEPTH = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [brbf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [brbf_pkg::CFG_DATA_W-1:0] cfg_data,
    input  wire logic                            req_valid,
    output logic                                 req_stall,
    input  wire logic [1:0]                      action,
    input  wire logic [brbf_pkg::DATA_W-1:0]     data_byte,
    input  wire logic [brbf_pkg::LEN_W-1:0]      length,
    input  wire logic                            first_of_run,
    output logic                                 rsp_valid,
    input  wire logic                            rsp_stall,
    output logic [brbf_pkg::DATA_W-1:0]          out_byte,
    output logic [brbf_pkg::LEN_W-1:0]           count,
    output logic                                 accepted,
    output logic                                 last
);

    localparam int AW = $clog2(DEPTH);

    brbf_pkg::cmd_t    cmd;
    brbf_pkg::status_t status;

    logic                         ram_we;
    logic [AW-1:0]                ram_waddr;
    logic [brbf_pkg::DATA_W-1:0]  ram_wdata;
    logic [AW-1:0]                ram_raddr;
    logic [brbf_pkg::DATA_W-1:0]  ram_rdata;

    assign cfg_ready = 1'b1;

    brbf_ram #(
        .WIDTH (brbf_pkg::DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    brbf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .status    (status),
        .cmd       (cmd)
    );

    brbf_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .action       (action),
        .data_byte    (data_byte),
        .length       (length),
        .first_of_run (first_of_run),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_raddr    (ram_raddr),
        .ram_rdata    (ram_rdata),
        .out_byte     (out_byte),
        .count        (count),
        .accepted     (accepted),
        .last         (last)
    );

endmodule

`default_nettype wire

// ===== design/brbf_checker.sv =====
// Port-level assertions for the byte ring buffer FIFO, bound to the top.
// Depends on brbf_pkg and byte_ring_buffer_fifo_top.
`default_nettype none

module brbf_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            req_valid,
    input wire logic                            req_stall,
    input wire logic                            rsp_valid,
    input wire logic                            rsp_stall,
    input wire logic [brbf_pkg::DATA_W-1:0]     out_byte,
    input wire logic [brbf_pkg::LEN_W-1:0]      count,
    input wire logic                            accepted,
    input wire logic                            last
);

    // held response keeps its payload
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(out_byte) && $stable(count)
            && $stable(accepted) && $stable(last))
        else $error("response changed while stalled");

    // no request transfer while a response is pending
    a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |-> !rsp_valid)
        else $error("request taken with a response pending");

    // a response that moved nothing carries no byte and ends the operation
    a_empty_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !accepted |-> out_byte == '0 && last)
        else $error("unaccepted response with byte or without last");

    // a mid-run response always delivers a byte
    a_mid_run: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !last |-> accepted && count != '0)
        else $error("non-final response without delivered byte");

endmodule

bind byte_ring_buffer_fifo_top brbf_checker u_brbf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .out_byte  (out_byte),
    .count     (count),
    .accepted  (accepted),
    .last      (last)
);

`default_nettype wire
